>>> rtl/n2d_pkg.sv
// ----------------------------------------------------------------------------
// n2d_pkg
// Shared types and constants for the NFA to DFA subset construction block.
// ----------------------------------------------------------------------------
package n2d_pkg;

    // Default sizes of the NFA table
    localparam int DEF_MAX_NFA_STATES = 8;
    localparam int DEF_MAX_SYMBOLS    = 4;

    // DFA id space and the "no transition" code
    localparam int         MAX_IDS = 256;
    localparam logic [8:0] NONE_ID = 9'h1FF;

    // Configuration register indexes
    localparam logic [1:0] REG_NFA_STATE_COUNT = 2'd0;
    localparam logic [1:0] REG_SYMBOL_COUNT    = 2'd1;
    localparam logic [1:0] REG_FINAL_MASK      = 2'd2;

    // Request modes
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_CONV = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SEED,
        ST_ROW,
        ST_SUB,
        ST_ACC,
        ST_ACCW,
        ST_SYM,
        ST_LOOK,
        ST_WROW,
        ST_DONE,
        ST_RD
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_entry;  // write one NFA table entry
        logic rd_issue;    // read subset and DFA row at row_id
        logic conv_start;  // clear id map, set counts
        logic seed;        // write one singleton subset
        logic sub_issue;   // read subset of the current row
        logic sub_latch;   // capture subset, clear unions
        logic acc_issue;   // read NFA row of the current member
        logic sym_issue;   // look up id of the current union
        logic sym_look;    // resolve or assign the id
        logic row_write;   // store the DFA row, next row
        logic out_load;    // load the result register
        logic out_row;     // result carries the read row
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic seed_last;
        logic row_end;
        logic m_last;
        logic j_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/n2d_ctrl.sv
// ----------------------------------------------------------------------------
// n2d_ctrl
// Sequencer for load, read and subset construction requests.
// ----------------------------------------------------------------------------
module n2d_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    mode,
    input  n2d_pkg::sts_t sts,
    output n2d_pkg::cmd_t cmd
);
    import n2d_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   fire;
    mode_t  req_mode;

    assign req_mode = mode_t'(mode);
    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign fire     = in_valid && in_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire && req_mode == MODE_CONV)
                begin
                    state_next = ST_START;
                end
                else if (fire && req_mode == MODE_READ)
                begin
                    state_next = ST_RD;
                end
            end
            ST_START: state_next = ST_SEED;
            ST_SEED:
            begin
                if (sts.seed_last)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:   state_next = sts.row_end ? ST_DONE : ST_SUB;
            ST_SUB:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (sts.m_last)
                begin
                    state_next = ST_ACCW;
                end
            end
            ST_ACCW:  state_next = ST_SYM;
            ST_SYM:   state_next = ST_LOOK;
            ST_LOOK:  state_next = sts.j_last ? ST_WROW : ST_SYM;
            ST_WROW:  state_next = ST_ROW;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_entry = fire && (req_mode == MODE_LOAD);
                cmd.rd_issue   = fire && (req_mode == MODE_READ);
                cmd.out_load   = fire && (req_mode == MODE_LOAD || req_mode == MODE_NOP);
            end
            ST_START: cmd.conv_start = 1'b1;
            ST_SEED:  cmd.seed       = 1'b1;
            ST_ROW:   cmd.sub_issue  = !sts.row_end;
            ST_SUB:   cmd.sub_latch  = 1'b1;
            ST_ACC:   cmd.acc_issue  = 1'b1;
            ST_SYM:   cmd.sym_issue  = 1'b1;
            ST_LOOK:  cmd.sym_look   = 1'b1;
            ST_WROW:  cmd.row_write  = 1'b1;
            ST_DONE:  cmd.out_load   = sts.out_free;
            ST_RD:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_row  = 1'b1;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

>>> rtl/n2d_dp.sv
// ----------------------------------------------------------------------------
// n2d_dp
// Datapath: NFA table, subset and id maps, DFA rows, counters, result register.
// ----------------------------------------------------------------------------
module n2d_dp #(
    parameter int MAX_NFA_STATES = n2d_pkg::DEF_MAX_NFA_STATES,
    parameter int MAX_SYMBOLS    = n2d_pkg::DEF_MAX_SYMBOLS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  n2d_pkg::cmd_t     cmd,
    output n2d_pkg::sts_t     sts,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic [2:0]        src_state,
    input  logic [1:0]        symbol,
    input  logic [7:0]        target_mask,
    input  logic [7:0]        row_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [8:0]        state_count,
    output logic [7:0]        row_subset,
    output logic              row_accepting,
    output logic signed [8:0] next_sym0,
    output logic signed [8:0] next_sym1,
    output logic signed [8:0] next_sym2,
    output logic signed [8:0] next_sym3
);
    import n2d_pkg::*;

    localparam int ST_W  = $clog2(MAX_NFA_STATES);
    localparam int SYM_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    // Configuration
    logic [3:0] nsc_reg;
    logic [2:0] symc_reg;
    logic [7:0] fmask_reg;
    logic [3:0] n_eff;
    logic [2:0] s_eff;
    logic [7:0] nmask;

    // Memories
    logic [7:0] nfa_mem [MAX_NFA_STATES][MAX_SYMBOLS];
    logic [7:0] sub_mem [MAX_IDS];
    logic [8:0] id_mem  [MAX_IDS];
    logic [8:0] dfa_mem [MAX_IDS][MAX_SYMBOLS];
    logic [MAX_IDS-1:0] id_vld_reg;

    // Read data registers
    logic [7:0] nfa_rd_reg [MAX_SYMBOLS];
    logic [7:0] sub_rd_reg;
    logic [8:0] id_rd_reg;
    logic       id_hit_reg;
    logic [8:0] dfa_rd_reg [MAX_SYMBOLS];
    logic       row_ok_reg;

    // Walk state
    logic [8:0]       count_reg;
    logic [8:0]       pp_reg;
    logic [ST_W-1:0]  i_reg;
    logic [ST_W-1:0]  m_reg;
    logic [SYM_W-1:0] j_reg;
    logic [7:0]       subset_reg;
    logic             acc_en_reg;
    logic [7:0]       union_reg [MAX_SYMBOLS];
    logic [7:0]       t_reg;
    logic [8:0]       nxt_reg [MAX_SYMBOLS];

    logic       load_ok;
    logic [8:0] nxt_id;
    logic       look_active;

    // Result register
    logic       out_valid_reg;
    logic [8:0] cnt_out_reg;
    logic [7:0] sub_out_reg;
    logic       acc_out_reg;
    logic [8:0] nxt_out_reg [4];
    logic [8:0] row_next [4];

    // Saturated counts
    always_comb
    begin
        if (nsc_reg == 4'd0)
        begin
            n_eff = 4'd1;
        end
        else if (nsc_reg > 4'(MAX_NFA_STATES))
        begin
            n_eff = 4'(MAX_NFA_STATES);
        end
        else
        begin
            n_eff = nsc_reg;
        end
        if (symc_reg == 3'd0)
        begin
            s_eff = 3'd1;
        end
        else if (symc_reg > 3'(MAX_SYMBOLS))
        begin
            s_eff = 3'(MAX_SYMBOLS);
        end
        else
        begin
            s_eff = symc_reg;
        end
    end

    assign nmask = 8'((9'd1 << n_eff) - 9'd1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsc_reg   <= 4'd1;
            symc_reg  <= 3'd1;
            fmask_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NFA_STATE_COUNT: nsc_reg   <= cfg_wdata[3:0];
                REG_SYMBOL_COUNT:    symc_reg  <= cfg_wdata[2:0];
                REG_FINAL_MASK:      fmask_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // NFA table: per-entry write, whole-row read
    assign load_ok = (4'(src_state) < 4'(MAX_NFA_STATES)) && (3'(symbol) < 3'(MAX_SYMBOLS));

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry && load_ok)
        begin
            nfa_mem[src_state[ST_W-1:0]][symbol[SYM_W-1:0]] <= target_mask;
        end
        if (cmd.acc_issue)
        begin
            nfa_rd_reg <= nfa_mem[m_reg];
        end
    end

    // Id lookup result for the symbol being resolved
    always_comb
    begin
        look_active = (3'(j_reg) < s_eff) && (t_reg != 8'd0);
        if (!look_active)
        begin
            nxt_id = NONE_ID;
        end
        else if (!id_hit_reg)
        begin
            nxt_id = count_reg;
        end
        else
        begin
            nxt_id = id_rd_reg;
        end
    end

    // Subset map
    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            sub_mem[8'(i_reg)] <= 8'(8'd1 << i_reg);
        end
        else if (cmd.sym_look && look_active && !id_hit_reg)
        begin
            sub_mem[count_reg[7:0]] <= t_reg;
        end
        if (cmd.rd_issue || cmd.sub_issue)
        begin
            sub_rd_reg <= sub_mem[cmd.rd_issue ? row_id : pp_reg[7:0]];
        end
    end

    // Id map
    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            id_mem[8'(8'd1 << i_reg)] <= 9'(i_reg);
        end
        else if (cmd.sym_look && look_active && !id_hit_reg)
        begin
            id_mem[t_reg] <= count_reg;
        end
        if (cmd.sym_issue)
        begin
            id_rd_reg <= id_mem[union_reg[j_reg] & nmask];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_vld_reg <= '0;
        end
        else if (cmd.conv_start)
        begin
            id_vld_reg <= '0;
        end
        else if (cmd.seed)
        begin
            id_vld_reg[8'(8'd1 << i_reg)] <= 1'b1;
        end
        else if (cmd.sym_look && look_active && !id_hit_reg)
        begin
            id_vld_reg[t_reg] <= 1'b1;
        end
    end

    // DFA rows
    always_ff @(posedge clk)
    begin
        if (cmd.row_write)
        begin
            dfa_mem[pp_reg[7:0]] <= nxt_reg;
        end
        if (cmd.rd_issue)
        begin
            dfa_rd_reg <= dfa_mem[row_id];
            row_ok_reg <= ({1'b0, row_id} < count_reg);
        end
    end

    // Walk counters and unions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 9'd0;
            pp_reg     <= 9'd0;
            i_reg      <= '0;
            m_reg      <= '0;
            j_reg      <= '0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.acc_issue && subset_reg[3'(m_reg)];
            if (cmd.conv_start)
            begin
                count_reg <= 9'(n_eff);
                pp_reg    <= 9'd0;
                i_reg     <= '0;
            end
            if (cmd.seed)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.sub_latch)
            begin
                m_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.acc_issue)
            begin
                m_reg <= m_reg + 1'b1;
            end
            if (cmd.sym_look)
            begin
                j_reg <= j_reg + 1'b1;
                if (look_active && !id_hit_reg)
                begin
                    count_reg <= count_reg + 9'd1;
                end
            end
            if (cmd.row_write)
            begin
                pp_reg <= pp_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sub_latch)
        begin
            subset_reg <= sub_rd_reg;
            for (int k = 0; k < MAX_SYMBOLS; k++)
            begin
                union_reg[k] <= 8'd0;
            end
        end
        else if (acc_en_reg)
        begin
            for (int k = 0; k < MAX_SYMBOLS; k++)
            begin
                union_reg[k] <= union_reg[k] | nfa_rd_reg[k];
            end
        end
        if (cmd.sym_issue)
        begin
            t_reg      <= union_reg[j_reg] & nmask;
            id_hit_reg <= id_vld_reg[union_reg[j_reg] & nmask];
        end
        if (cmd.sym_look)
        begin
            nxt_reg[j_reg] <= nxt_id;
        end
    end

    // Status
    assign sts.seed_last = (4'(i_reg) == n_eff - 4'd1);
    assign sts.m_last    = (4'(m_reg) == n_eff - 4'd1);
    assign sts.j_last    = (j_reg == SYM_W'(MAX_SYMBOLS - 1));
    assign sts.row_end   = (pp_reg >= count_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Next ids of the read row, unused lanes give none
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            row_next[k] = NONE_ID;
        end
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            row_next[k] = dfa_rd_reg[k];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cnt_out_reg <= count_reg;
            if (cmd.out_row && row_ok_reg)
            begin
                sub_out_reg <= sub_rd_reg;
                acc_out_reg <= |(sub_rd_reg & fmask_reg);
                nxt_out_reg <= row_next;
            end
            else
            begin
                sub_out_reg <= 8'd0;
                acc_out_reg <= 1'b0;
                for (int k = 0; k < 4; k++)
                begin
                    nxt_out_reg[k] <= NONE_ID;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign state_count   = cnt_out_reg;
    assign row_subset    = sub_out_reg;
    assign row_accepting = acc_out_reg;
    assign next_sym0     = nxt_out_reg[0];
    assign next_sym1     = nxt_out_reg[1];
    assign next_sym2     = nxt_out_reg[2];
    assign next_sym3     = nxt_out_reg[3];

`ifndef SYNTH
    // The walk never passes the end of the id list
    a_pp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pp_reg <= count_reg)
        else $error("row pointer beyond DFA state count");

    // A row is stored only for an existing DFA state
    a_row_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_write |-> (pp_reg < count_reg))
        else $error("row write past DFA state count");

    // A result is never loaded over one still waiting
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // Ids stay inside the id space
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 9'(MAX_IDS - 1))
        else $error("DFA state count overflow");
`endif

endmodule

>>> rtl/nfa_to_dfa_subset_construction.sv
// ----------------------------------------------------------------------------
// nfa_to_dfa_subset_construction
// NFA table load, subset construction and DFA row read-back.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | mode, src_state, symbol, target_mask,
//           |                       | row_id
//  out      | out_valid / out_ready | state_count, row_subset, row_accepting,
//           |                       | next_sym0..next_sym3
//  cfg      | cfg_we                | cfg_index, cfg_wdata
//
//  Load and no-op requests load the result from the idle state; a read first
//  registers the subset and DFA row at row_id, then loads the result.
//  A convert request seeds the N singleton subsets, then for each of the D
//  resulting DFA states reads its subset, the NFA row of every NFA state and does one id map lookup per symbol lane.
//  One request at a time; a new one is taken while the result is being taken.
//  Reset clears the control state and the id map valid bits.
// ----------------------------------------------------------------------------
module nfa_to_dfa_subset_construction #(
    parameter int MAX_NFA_STATES = n2d_pkg::DEF_MAX_NFA_STATES,
    parameter int MAX_SYMBOLS    = n2d_pkg::DEF_MAX_SYMBOLS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [2:0]        src_state,
    input  logic [1:0]        symbol,
    input  logic [7:0]        target_mask,
    input  logic [7:0]        row_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [8:0]        state_count,
    output logic [7:0]        row_subset,
    output logic              row_accepting,
    output logic signed [8:0] next_sym0,
    output logic signed [8:0] next_sym1,
    output logic signed [8:0] next_sym2,
    output logic signed [8:0] next_sym3
);
    import n2d_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    n2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    n2d_dp #(
        .MAX_NFA_STATES (MAX_NFA_STATES),
        .MAX_SYMBOLS    (MAX_SYMBOLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .src_state     (src_state),
        .symbol        (symbol),
        .target_mask   (target_mask),
        .row_id        (row_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .state_count   (state_count),
        .row_subset    (row_subset),
        .row_accepting (row_accepting),
        .next_sym0     (next_sym0),
        .next_sym1     (next_sym1),
        .next_sym2     (next_sym2),
        .next_sym3     (next_sym3)
    );

endmodule
